// ===== rtl/ddf_pkg.sv =====
// types, constants and helpers for the decimal display formatter
// no dependencies; imported by every rtl module of the block

package ddf_pkg;

  localparam int unsigned NUM_BITS   = 30;
  localparam int unsigned NUM_DIGITS = 9;
  localparam int unsigned NUM_CHARS  = 6;

  localparam logic [5:0] CH_SPACE = 6'h20;
  localparam logic [5:0] CH_ZERO  = 6'h30;

  localparam logic [1:0] ROW_TOP    = 2'd0;
  localparam logic [1:0] ROW_MIDDLE = 2'd1;

  localparam logic [1:0] REG_DEC_ROW0 = 2'd0;
  localparam logic [1:0] REG_DEC_ROW1 = 2'd1;
  localparam logic [1:0] REG_DEC_ROW2 = 2'd2;

  localparam logic [2:0] DEC_ROW0_RST = 3'd1;
  localparam logic [2:0] DEC_ROW1_RST = 3'd2;
  localparam logic [2:0] DEC_ROW2_RST = 3'd2;
  localparam logic [2:0] DEC_AUTO     = 3'd4;

  // largest unrounded value in thousandths for 0..3 decimals
  localparam logic [NUM_BITS-1:0] LIMIT_MILLI [4] = '{
    30'd999999000, 30'd99999900, 30'd9999990, 30'd999999
  };
  // half of the dropped unit, in thousandths
  localparam logic [9:0] HALF_MILLI [4] = '{10'd500, 10'd50, 10'd5, 10'd0};

  typedef struct packed {
    logic [NUM_BITS-1:0] value_milli;
    logic [1:0]          row_select;
  } ddf_in_t;

  typedef struct packed {
    logic [5:0] char_0;
    logic [5:0] char_1;
    logic [5:0] char_2;
    logic [5:0] char_3;
    logic [5:0] char_4;
    logic [5:0] char_5;
    logic [5:0] point_code;
    logic       blanked;
  } ddf_out_t;

  // data handed from cell to cell
  typedef struct packed {
    logic [NUM_BITS-1:0]     bin;
    logic [NUM_DIGITS*4-1:0] bcd;
    logic [1:0]              dec;
    logic                    ok;
    logic                    bottom;
  } ddf_work_t;

  function automatic logic [3:0] add3(input logic [3:0] dig);
    add3 = (dig >= 4'd5) ? dig + 4'd3 : dig;
  endfunction

endpackage

// ===== rtl/decimal_display_formatter.sv =====
// decimal display formatter: thousandths value to six ascii characters
// front cell, 30 dabble cells, format cell; one beat per cycle unless result stalls
// each cell is an elastic stage, so bubbles collapse while the result side stalls
// synchronous active-high reset clears all valid bits and loads the row decimals
// to 1, 2 and 2; payload registers are not reset
// depends on ddf_pkg, ddf_front, ddf_dabble_cell, ddf_format

module decimal_display_formatter (
  input  logic              clk,
  input  logic              rst,
  // config write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  // item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  ddf_pkg::ddf_in_t  item,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output ddf_pkg::ddf_out_t result
);
  import ddf_pkg::*;

  // per-row decimals, 4..7 select auto range
  logic [2:0] dec_row0;
  logic [2:0] dec_row1;
  logic [2:0] dec_row2;

  // chain links: link 0 leaves the front cell, link NUM_BITS enters the formatter
  logic      link_valid [NUM_BITS+1];
  logic      link_ready [NUM_BITS+1];
  ddf_work_t link       [NUM_BITS+1];

  // config writes are always taken; index three is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_row0 <= DEC_ROW0_RST;
      dec_row1 <= DEC_ROW1_RST;
      dec_row2 <= DEC_ROW2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEC_ROW0: dec_row0 <= cfg_data;
        REG_DEC_ROW1: dec_row1 <= cfg_data;
        REG_DEC_ROW2: dec_row2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // range check and rounding; the rounded value in thousandths enters the chain
  ddf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dec_row0 (dec_row0),
    .dec_row1 (dec_row1),
    .dec_row2 (dec_row2),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .up       (item),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn       (link[0])
  );

  // one dabble cell per input bit, msb first, into nine bcd digits
  for (genvar g = 0; g < NUM_BITS; g++) begin : g_cell
    ddf_dabble_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[g]),
      .up_ready (link_ready[g]),
      .up       (link[g]),
      .dn_valid (link_valid[g+1]),
      .dn_ready (link_ready[g+1]),
      .dn       (link[g+1])
    );
  end

  // digit selection, leading blanks and output register
  ddf_format u_format (
    .clk      (clk),
    .rst      (rst),
    .up_valid (link_valid[NUM_BITS]),
    .up_ready (link_ready[NUM_BITS]),
    .up       (link[NUM_BITS]),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn       (result)
  );

endmodule

// ===== rtl/ddf_front.sv =====
// first cell: row config select, range check, decimals pick, rounding add
// depends on ddf_pkg

module ddf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        dec_row0,
  input  logic [2:0]        dec_row1,
  input  logic [2:0]        dec_row2,
  input  logic              up_valid,
  output logic              up_ready,
  input  ddf_pkg::ddf_in_t  up,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ddf_pkg::ddf_work_t dn
);
  import ddf_pkg::*;

  ddf_work_t work_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    logic [2:0]          cfg;
    logic [1:0]          d;
    logic                ok;
    logic [NUM_BITS:0]   sum;
    cfg = dec_row2;
    if (up.row_select == ROW_TOP) begin
      cfg = dec_row0;
    end else if (up.row_select == ROW_MIDDLE) begin
      cfg = dec_row1;
    end
    d  = cfg[1:0];
    ok = 1'b0;
    if (cfg < DEC_AUTO) begin
      ok = up.value_milli <= LIMIT_MILLI[cfg[1:0]];
    end else if (up.value_milli <= LIMIT_MILLI[3]) begin
      d  = 2'd3;
      ok = 1'b1;
    end else if (up.value_milli <= LIMIT_MILLI[2]) begin
      d  = 2'd2;
      ok = 1'b1;
    end else if (up.value_milli <= LIMIT_MILLI[1]) begin
      d  = 2'd1;
      ok = 1'b1;
    end else if (up.value_milli <= LIMIT_MILLI[0]) begin
      d  = 2'd0;
      ok = 1'b1;
    end
    // in range the rounded sum stays below one billion
    sum = {1'b0, up.value_milli} + (NUM_BITS+1)'(HALF_MILLI[d]);
    work_next.bin    = ok ? sum[NUM_BITS-1:0] : '0;
    work_next.bcd    = '0;
    work_next.dec    = ok ? d : 2'd0;
    work_next.ok     = ok;
    work_next.bottom = up.row_select[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= work_next;
    end
  end

endmodule

// ===== rtl/ddf_dabble_cell.sv =====
// one shift-add-3 step of the binary to bcd conversion, registered
// depends on ddf_pkg

module ddf_dabble_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ddf_pkg::ddf_work_t up,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ddf_pkg::ddf_work_t dn
);
  import ddf_pkg::*;

  ddf_work_t work_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    logic [NUM_DIGITS*4-1:0] adj;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = add3(up.bcd[i*4 +: 4]);
    end
    work_next     = up;
    work_next.bcd = {adj[NUM_DIGITS*4-2:0], up.bin[NUM_BITS-1]};
    work_next.bin = {up.bin[NUM_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= work_next;
    end
  end

endmodule

// ===== rtl/ddf_format.sv =====
// last cell: digit pick by decimals, overflow check, blanking, ascii pack
// depends on ddf_pkg

module ddf_format (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ddf_pkg::ddf_work_t up,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ddf_pkg::ddf_out_t  dn
);
  import ddf_pkg::*;

  ddf_out_t res_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    logic [3:0] dig [NUM_DIGITS];
    logic [3:0] n [NUM_CHARS];
    logic [3:0] idx;
    logic       ovf;
    logic       ok;
    logic       nz;
    logic [5:0] ch [NUM_CHARS];
    for (int j = 0; j < NUM_DIGITS; j++) begin
      dig[j] = up.bcd[j*4 +: 4];
    end
    // drop the low 3-d digits of the thousandths value
    for (int k = 0; k < NUM_CHARS; k++) begin
      idx  = 4'(k + 3) - {2'b00, up.dec};
      n[k] = dig[idx];
    end
    // rounded value wider than six digits
    ovf = 1'b0;
    for (int j = NUM_CHARS; j < NUM_DIGITS; j++) begin
      if ((j + 32'(up.dec) >= NUM_DIGITS) && (dig[j] != 4'd0)) begin
        ovf = 1'b1;
      end
    end
    ok = up.ok && !ovf;
    nz = 1'b0;
    for (int i = NUM_CHARS - 1; i >= 0; i--) begin
      nz = nz || (n[i] != 4'd0);
      if (ok && ((i <= 32'(up.dec)) || nz)) begin
        ch[NUM_CHARS-1-i] = CH_ZERO + {2'b00, n[i]};
      end else begin
        ch[NUM_CHARS-1-i] = CH_SPACE;
      end
    end
    if (up.bottom) begin
      res_next.char_0 = ch[2];
      res_next.char_1 = ch[3];
      res_next.char_2 = ch[4];
      res_next.char_3 = ch[5];
      res_next.char_4 = CH_SPACE;
      res_next.char_5 = CH_SPACE;
    end else begin
      res_next.char_0 = ch[0];
      res_next.char_1 = ch[1];
      res_next.char_2 = ch[2];
      res_next.char_3 = ch[3];
      res_next.char_4 = ch[4];
      res_next.char_5 = ch[5];
    end
    res_next.point_code = ok ? CH_ZERO + {4'b0000, up.dec} : CH_ZERO;
    res_next.blanked    = !ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= res_next;
    end
  end

endmodule

// ===== tb/display_checker.sv =====
// checker for the decimal display formatter: follows the row decimals written on the
// config channel, predicts each row text and compares it with the result beats
// depends on ddf_pkg for the port structs and reset values
`timescale 1ns / 100ps

module display_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  input  logic              item_valid,
  input  logic              item_ready,
  input  ddf_pkg::ddf_in_t  item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  ddf_pkg::ddf_out_t result,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       checked
);
  import ddf_pkg::*;

  localparam int unsigned MAX_SHOWN [4] = '{999999000, 99999900, 9999990, 999999};
  localparam int unsigned STEP_MILLI [4] = '{1000, 100, 10, 1};
  localparam int unsigned SIX_DIGITS = 999999;
  localparam logic [2:0] DEC_FIXED_MAX = 3'd3;

  logic [2:0] dec_row [3];
  ddf_out_t predicted_rows [$];
  int unsigned errs = 0;
  int unsigned compared = 0;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  function automatic ddf_out_t format_row(input logic [NUM_BITS-1:0] v, input logic [1:0] row);
    logic [5:0] text [6];
    logic [2:0] dec_cfg;
    logic [1:0] dec;
    logic fits;
    int unsigned shown;
    int unsigned rest;
    int unsigned step_milli;
    ddf_out_t res;
    dec_cfg = (row == ROW_TOP) ? dec_row[0] : (row == ROW_MIDDLE) ? dec_row[1] : dec_row[2];
    dec = 2'd0;
    fits = 1'b0;
    if (dec_cfg <= DEC_FIXED_MAX) begin
      dec = dec_cfg[1:0];
      fits = (v <= MAX_SHOWN[dec]);
    end else begin
      // auto range: most decimals whose limit holds
      for (int k = 3; k >= 0; k--) begin
        if (!fits && v <= MAX_SHOWN[k]) begin
          dec = 2'(k);
          fits = 1'b1;
        end
      end
    end
    shown = 0;
    if (fits) begin
      step_milli = STEP_MILLI[dec];
      shown = (32'(v) + step_milli / 2) / step_milli;
      if (shown > SIX_DIGITS) fits = 1'b0;
    end
    rest = shown;
    for (int i = 0; i < 6; i++) begin
      if (fits && (i <= dec || rest != 0)) text[5-i] = CH_ZERO + 6'(rest % 10);
      else text[5-i] = CH_SPACE;
      rest = rest / 10;
    end
    if (!fits) dec = 2'd0;
    if (row == ROW_TOP || row == ROW_MIDDLE) begin
      res.char_0 = text[0];
      res.char_1 = text[1];
      res.char_2 = text[2];
      res.char_3 = text[3];
      res.char_4 = text[4];
      res.char_5 = text[5];
    end else begin
      res.char_0 = text[2];
      res.char_1 = text[3];
      res.char_2 = text[4];
      res.char_3 = text[5];
      res.char_4 = CH_SPACE;
      res.char_5 = CH_SPACE;
    end
    res.point_code = CH_ZERO + 6'(dec);
    res.blanked = !fits;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    ddf_out_t want;
    if (rst) begin
      dec_row[0] = DEC_ROW0_RST;
      dec_row[1] = DEC_ROW1_RST;
      dec_row[2] = DEC_ROW2_RST;
      predicted_rows.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (predicted_rows.size() == 0) begin
          $error("result beat with no prediction waiting: %h", result);
          errs++;
        end else begin
          want = predicted_rows.pop_front();
          compared++;
          check_field("char_0", want.char_0, result.char_0);
          check_field("char_1", want.char_1, result.char_1);
          check_field("char_2", want.char_2, result.char_2);
          check_field("char_3", want.char_3, result.char_3);
          check_field("char_4", want.char_4, result.char_4);
          check_field("char_5", want.char_5, result.char_5);
          check_field("point_code", want.point_code, result.point_code);
          check_field("blanked", 6'(want.blanked), 6'(result.blanked));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEC_ROW0: dec_row[0] = cfg_data;
          REG_DEC_ROW1: dec_row[1] = cfg_data;
          REG_DEC_ROW2: dec_row[2] = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        predicted_rows.push_back(format_row(item.value_milli, item.row_select));
    end
    fail_count <= errs;
    pending <= predicted_rows.size();
    checked <= compared;
  end

endmodule

// ===== tb/testbench.sv =====
// top of the decimal display formatter bench: clock, reset, stimulus and verdict
// depends on ddf_pkg, decimal_display_formatter and display_checker
`timescale 1ns / 100ps

module testbench;
  import ddf_pkg::*;

  localparam int unsigned HALF_PERIOD_NS = 6;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned PIPE_DEPTH = 32;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 236;
  localparam int unsigned NUM_PHASES = 5;

  localparam logic [1:0] ROW_BOTTOM = 2'd2;
  localparam logic [1:0] ROW_ALIAS = 2'd3;     // row code three acts as bottom
  localparam logic [1:0] REG_SPARE = 2'd3;     // no register behind this index
  localparam logic [2:0] DEC_AUTO_5 = 3'd5;    // codes above auto also mean auto
  localparam logic [2:0] DEC_AUTO_6 = 3'd6;
  localparam logic [2:0] DEC_AUTO_7 = 3'd7;
  localparam logic [NUM_BITS-1:0] MILLI_MAX = '1;

  localparam int unsigned EDGE_MILLI [4] = '{999999000, 99999900, 9999990, 999999};
  localparam int unsigned STEP_MILLI [4] = '{1000, 100, 10, 1};

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [2:0] cfg_data;
  logic item_valid;
  logic item_ready;
  ddf_in_t item;
  logic result_valid;
  logic result_ready;
  ddf_out_t result;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // idle odds in percent per cycle, changed by the stimulus per phase
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 60;
  // set by the stimulus, cleared by the receiver once its long stall is over
  logic hold_req = 1'b0;

  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  always #HALF_PERIOD_NS clk = ~clk;

  decimal_display_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  display_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // value mix: full-width noise, values around each range limit, values right on
  // a rounding boundary, magnitudes spread over every bit position, and small values
  function automatic logic [NUM_BITS-1:0] pick_milli();
    int unsigned kind;
    int unsigned base;
    int unsigned step_milli;
    kind = $urandom_range(0, 5);
    case (kind)
      0: return NUM_BITS'($urandom);
      1: begin
        base = EDGE_MILLI[$urandom_range(0, 3)];
        return NUM_BITS'(base - 1000 + $urandom_range(0, 2000));
      end
      2: return NUM_BITS'($urandom_range(0, 99999));
      3: return NUM_BITS'($urandom >> $urandom_range(2, 31));
      4: begin
        // just below or on the half-up point of the dropped unit
        step_milli = STEP_MILLI[$urandom_range(0, 3)];
        base = $urandom_range(0, 1000000);
        return NUM_BITS'(base * step_milli + step_milli / 2 - $urandom_range(0, 1));
      end
      default: return NUM_BITS'($urandom_range(0, 9999999));
    endcase
  endfunction

  // one item beat; the sender may idle first, valid then holds until accepted
  task automatic send_item(input logic [NUM_BITS-1:0] v, input logic [1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{value_milli: v, row_select: row};
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  // config beat; valid is left high after the write, so back-to-back writes keep it asserted
  task automatic write_reg(input logic [1:0] index, input logic [2:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  // stop offering items and wait for every predicted row to come back;
  // the first edge lets the checker count the last accepted item
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // new decimals for all rows, only with the block empty;
  // the spare index is hit too and must change nothing
  task automatic set_decimals(input logic [2:0] d0, input logic [2:0] d1, input logic [2:0] d2);
    wait_drained();
    write_reg(REG_DEC_ROW0, d0);
    write_reg(REG_DEC_ROW1, d1);
    write_reg(REG_DEC_ROW2, d2);
    write_reg(REG_SPARE, 3'($urandom_range(0, 7)));
    cfg_valid <= 1'b0;
  endtask

  // receiver: random ready, or one long stall when the stimulus asks for it
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still expected", cycle_count, pending);
      $display("decimal_display_formatter test failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] phase_dec [NUM_PHASES][3];
    // decimals per random phase: fixed decimals, auto, and the codes above auto
    phase_dec[0] = '{3'd3, 3'd0, DEC_AUTO};
    phase_dec[1] = '{DEC_AUTO, 3'd2, 3'd0};
    phase_dec[2] = '{DEC_AUTO_5, DEC_AUTO_6, DEC_AUTO_7};
    phase_dec[3] = '{3'd1, 3'd3, 3'd3};
    phase_dec[4] = '{3'd0, DEC_AUTO, 3'd1};

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_DEC_ROW0;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed, reset decimals 1, 2, 2: zero, full scale, exact limits and
    // just past them, row code three on the bottom row
    send_item('0, ROW_TOP);
    send_item('0, ROW_BOTTOM);
    send_item(MILLI_MAX, ROW_TOP);
    send_item(MILLI_MAX, ROW_BOTTOM);
    send_item(NUM_BITS'(99999900), ROW_TOP);
    send_item(NUM_BITS'(99999901), ROW_TOP);
    send_item(NUM_BITS'(9999990), ROW_MIDDLE);
    send_item(NUM_BITS'(9999994), ROW_ALIAS);
    send_item(NUM_BITS'(1235), ROW_ALIAS);
    send_item(NUM_BITS'(12344), ROW_MIDDLE);

    // auto range on every row: each choice of decimals, rounding that carries
    // into a new digit, and values no choice can show
    set_decimals(DEC_AUTO, DEC_AUTO, DEC_AUTO);
    send_item(NUM_BITS'(999999), ROW_TOP);
    send_item(NUM_BITS'(1000000), ROW_MIDDLE);
    send_item(NUM_BITS'(9999995), ROW_BOTTOM);
    send_item(NUM_BITS'(99999950), ROW_TOP);
    send_item(NUM_BITS'(999999000), ROW_MIDDLE);
    send_item(NUM_BITS'(999999001), ROW_TOP);
    send_item('0, ROW_BOTTOM);
    send_item(NUM_BITS'(500), ROW_ALIAS);

    // no decimals, three decimals and two on the bottom row: half-up on either side, blanking
    set_decimals(3'd0, 3'd3, 3'd2);
    send_item(NUM_BITS'(500), ROW_TOP);
    send_item(NUM_BITS'(499), ROW_TOP);
    send_item(NUM_BITS'(999999499), ROW_TOP);
    send_item(NUM_BITS'(999999), ROW_MIDDLE);
    send_item(NUM_BITS'(1000000), ROW_MIDDLE);
    send_item(NUM_BITS'(12345), ROW_BOTTOM);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender light and receiver heavy, then swapped, then no idling at all
      if (p < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 60;
      end else if (p < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_decimals(phase_dec[p][0], phase_dec[p][1], phase_dec[p][2]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // long result stall while items keep coming: pipeline fills, input backs up
        if (p == 1 && i == 60) hold_req = 1'b1;
        // sender pause until the block is empty, then restart from cold
        if (p == 3 && i == 120) wait_drained();
        send_item(pick_milli(), 2'($urandom_range(0, 3)));
      end
    end

    wait_drained();
    // any stray beat behind the last one shows up within the pipeline depth
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("covered %0d items on all row codes over %0d decimal settings, %0d config writes",
             items_sent, NUM_PHASES + 3, cfg_writes);
    $display("%0d result beats compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("decimal_display_formatter test passed");
    end else begin
      $display("decimal_display_formatter test failed");
    end
    $finish;
  end

endmodule
